// ----- rtl/core/mpq_pkg.sv -----
package mpq_pkg;

    localparam int PROC_COUNT_DEF = 16;
    localparam int NUM_LEVELS_DEF = 5;
    localparam int LOWEST_USER_LEVEL_DEF = 3;
    localparam int HIGHEST_USER_LEVEL_DEF = 0;

    localparam logic [2:0] OP_ENQ = 3'd0;
    localparam logic [2:0] OP_DEQ = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_MOVE = 3'd3;
    localparam logic [2:0] OP_HIGHEST = 3'd4;
    localparam logic [2:0] OP_SETPRI = 3'd5;
    localparam logic [2:0] OP_LOAD = 3'd6;
    localparam logic [2:0] OP_ILLEGAL = 3'd7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ERR = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic       queue_sel;
        logic [3:0] pid;
        logic [2:0] priority_req;
        logic [2:0] from_priority;
        logic [3:0] current_pid;
        logic       blocking;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] pid_out;
        logic [2:0] highest_level;
        logic       preempt;
    } res_t;

endpackage

// ----- rtl/core/multilevel_process_ready_queue.sv -----
// Highest, load and commands rejected at once finish straight after dispatch; enqueue
// passes through the push state; dequeue checks the head and, unless it is a single
// entry, reads its link. Remove and move walk the list entry by entry, with a further
// read when the entry found is not the tail; set priority may also walk both sets.
// One command at a time: busy drops in the strobe cycle, when the next one can be taken.
// Reset empties all lists and clears the priority table; the receiver cannot stall results.
module multilevel_process_ready_queue #(
    parameter int PROC_COUNT = mpq_pkg::PROC_COUNT_DEF,
    parameter int NUM_LEVELS = mpq_pkg::NUM_LEVELS_DEF,
    parameter int LOWEST_USER_LEVEL = mpq_pkg::LOWEST_USER_LEVEL_DEF,
    parameter int HIGHEST_USER_LEVEL = mpq_pkg::HIGHEST_USER_LEVEL_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mpq_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output mpq_pkg::res_t result
);

    localparam int PW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
    localparam int NQ = 2 * NUM_LEVELS;
    localparam int QW = $clog2(NQ);
    localparam int CW = $clog2(PROC_COUNT + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_READ = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_UNLINK = 4'd4;
    localparam logic [3:0] S_PUSH = 4'd5;
    localparam logic [3:0] S_PREEMPT = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;

    logic [PW-1:0] link_mem [PROC_COUNT];
    logic [PW-1:0] link_rdata_reg;
    logic          link_we;
    logic [PW-1:0] link_waddr;
    logic [PW-1:0] link_wdata;
    logic          link_re;
    logic [PW-1:0] link_raddr;

    logic [NQ-1:0]  hvalid_reg, hvalid_next;
    logic [PW-1:0]  head_reg [NQ];
    logic [PW-1:0]  tail_reg [NQ];
    logic [PW-1:0]  head_next [NQ];
    logic [PW-1:0]  tail_next [NQ];
    logic [2:0]     ptab_reg [PROC_COUNT];
    logic [2:0]     ptab_next [PROC_COUNT];
    logic [PROC_COUNT-1:0] tvalid_reg, tvalid_next;

    logic [3:0]    state_reg, state_next;
    mpq_pkg::cmd_t cmd_reg, cmd_next;
    mpq_pkg::res_t res_reg, res_next;
    logic          done_reg, done_next;
    logic          set_reg, set_next;
    logic [2:0]    src_reg, src_next;
    logic [PW-1:0] tpid_reg, tpid_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic          hasprev_reg, hasprev_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic          retry_reg, retry_next;

    function automatic logic may_enq(input logic [3:0] p, input logic [2:0] l);
        logic ok;
        ok = 1'b0;
        if (32'(l) < NUM_LEVELS)
        begin
            if (p == 4'd0)
            begin
                ok = 1'b1;
            end
            else
            begin
                ok = (32'(l) <= LOWEST_USER_LEVEL) && (32'(l) >= HIGHEST_USER_LEVEL);
            end
        end
        return ok;
    endfunction

    function automatic logic [2:0] high_of(input logic [NQ-1:0] v, input logic s);
        logic [2:0] h;
        h = 3'(NUM_LEVELS);
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (v[32'(s) * NUM_LEVELS + l])
            begin
                h = 3'(l);
            end
        end
        return h;
    endfunction

    logic [QW-1:0] qidx;
    logic [QW-1:0] sidx;
    logic [QW-1:0] didx;
    logic          pid_ok;
    logic          in_range_dst;

    always_comb
    begin
        qidx = QW'(32'(set_reg) * NUM_LEVELS + 32'(cmd_reg.priority_req));
        sidx = QW'(32'(set_reg) * NUM_LEVELS + 32'(src_reg));
        didx = QW'(32'(set_reg) * NUM_LEVELS + 32'(cmd_reg.priority_req));
        pid_ok = 32'(cmd_reg.pid) < PROC_COUNT;
        in_range_dst = 32'(cmd_reg.priority_req) < NUM_LEVELS;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        res_next = res_reg;
        done_next = 1'b0;
        set_next = set_reg;
        src_next = src_reg;
        tpid_next = tpid_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        hasprev_next = hasprev_reg;
        steps_next = steps_reg;
        retry_next = retry_reg;
        hvalid_next = hvalid_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        ptab_next = ptab_reg;
        tvalid_next = tvalid_reg;
        link_we = 1'b0;
        link_waddr = tail_reg[sidx];
        link_wdata = tpid_reg;
        link_re = 1'b0;
        link_raddr = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    set_next = cmd.queue_sel;
                    res_next = '0;
                    retry_next = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                tpid_next = PW'(cmd_reg.pid);
                case (cmd_reg.operation) inside
                    mpq_pkg::OP_ENQ:
                    begin
                        if (!pid_ok || !may_enq(cmd_reg.pid, cmd_reg.priority_req))
                        begin
                            res_next.status = mpq_pkg::ST_ERR;
                        end
                        else
                        begin
                            src_next = cmd_reg.priority_req;
                            state_next = S_PUSH;
                        end
                    end
                    mpq_pkg::OP_DEQ:
                    begin
                        if (!in_range_dst || !hvalid_reg[qidx])
                        begin
                            res_next.status = mpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_next.pid_out = 4'(head_reg[qidx]);
                            tpid_next = head_reg[qidx];
                            src_next = cmd_reg.priority_req;
                            cur_next = head_reg[qidx];
                            hasprev_next = 1'b0;
                            steps_next = '0;
                            state_next = S_CHECK;
                        end
                    end
                    mpq_pkg::OP_REMOVE, mpq_pkg::OP_MOVE:
                    begin
                        if (!pid_ok)
                        begin
                            res_next.status = mpq_pkg::ST_ERR;
                        end
                        else
                        begin
                            src_next = (cmd_reg.operation == mpq_pkg::OP_MOVE) ?
                                cmd_reg.from_priority : cmd_reg.priority_req;
                            state_next = S_UNLINK;
                        end
                    end
                    mpq_pkg::OP_HIGHEST:
                    begin
                    end
                    mpq_pkg::OP_SETPRI:
                    begin
                        set_next = 1'b0;
                        if (!pid_ok || cmd_reg.pid == 4'd0 ||
                            32'(cmd_reg.priority_req) > LOWEST_USER_LEVEL ||
                            32'(cmd_reg.priority_req) < HIGHEST_USER_LEVEL ||
                            !in_range_dst || !tvalid_reg[PW'(cmd_reg.pid)])
                        begin
                            res_next.status = mpq_pkg::ST_ERR;
                        end
                        else
                        begin
                            ptab_next[PW'(cmd_reg.pid)] = cmd_reg.priority_req;
                            res_next.pid_out = cmd_reg.pid;
                            if (ptab_reg[PW'(cmd_reg.pid)] != cmd_reg.priority_req)
                            begin
                                src_next = ptab_reg[PW'(cmd_reg.pid)];
                                state_next = S_UNLINK;
                            end
                        end
                    end
                    mpq_pkg::OP_LOAD:
                    begin
                        set_next = 1'b0;
                        if (!pid_ok)
                        begin
                            res_next.status = mpq_pkg::ST_ERR;
                        end
                        else
                        begin
                            ptab_next[PW'(cmd_reg.pid)] = cmd_reg.priority_req;
                            tvalid_next[PW'(cmd_reg.pid)] = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_next.status = mpq_pkg::ST_ERR;
                    end
                endcase
            end
            S_UNLINK:
            begin
                if (32'(src_reg) >= NUM_LEVELS || !hvalid_reg[sidx])
                begin
                    state_next = S_FINISH;
                    if (cmd_reg.operation == mpq_pkg::OP_SETPRI)
                    begin
                        if (!set_reg)
                        begin
                            set_next = 1'b1;
                            state_next = S_UNLINK;
                        end
                        else
                        begin
                            set_next = 1'b0;
                            state_next = S_PREEMPT;
                        end
                    end
                    else
                    begin
                        res_next.status = mpq_pkg::ST_EMPTY;
                    end
                end
                else
                begin
                    cur_next = head_reg[sidx];
                    hasprev_next = 1'b0;
                    steps_next = '0;
                    state_next = S_CHECK;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
                cur_next = link_rdata_reg;
            end
            S_CHECK:
            begin
                if (cur_reg == tpid_reg)
                begin
                    if (!hasprev_reg)
                    begin
                        if (cur_reg == tail_reg[sidx])
                        begin
                            hvalid_next[sidx] = 1'b0;
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            link_re = 1'b1;
                            state_next = S_READ;
                            retry_next = 1'b1;
                        end
                    end
                    else if (cur_reg == tail_reg[sidx])
                    begin
                        tail_next[sidx] = prev_reg;
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        link_re = 1'b1;
                        state_next = S_READ;
                        retry_next = 1'b1;
                    end
                    if (retry_reg)
                    begin
                        retry_next = 1'b0;
                    end
                end
                else if (cur_reg == tail_reg[sidx] || 32'(steps_reg) >= PROC_COUNT - 1)
                begin
                    state_next = S_FINISH;
                    if (cmd_reg.operation == mpq_pkg::OP_SETPRI)
                    begin
                        if (!set_reg)
                        begin
                            set_next = 1'b1;
                            state_next = S_UNLINK;
                        end
                        else
                        begin
                            set_next = 1'b0;
                            state_next = S_PREEMPT;
                        end
                    end
                    else
                    begin
                        res_next.status = mpq_pkg::ST_EMPTY;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    hasprev_next = 1'b1;
                    steps_next = steps_reg + CW'(1);
                    link_re = 1'b1;
                    state_next = S_READ;
                end
                if (retry_reg && cur_reg != tpid_reg)
                begin
                    retry_next = 1'b0;
                    state_next = S_PUSH;
                    if (!hasprev_reg)
                    begin
                        head_next[sidx] = cur_reg;
                        cur_next = tpid_reg;
                        hvalid_next = hvalid_reg;
                        tail_next = tail_reg;
                        prev_next = prev_reg;
                        hasprev_next = hasprev_reg;
                        steps_next = steps_reg;
                    end
                    else
                    begin
                        link_we = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = cur_reg;
                        cur_next = tpid_reg;
                        hvalid_next = hvalid_reg;
                        tail_next = tail_reg;
                        prev_next = prev_reg;
                        hasprev_next = hasprev_reg;
                        steps_next = steps_reg;
                    end
                    res_next.status = res_reg.status;
                    set_next = set_reg;
                end
            end
            S_PUSH:
            begin
                state_next = S_FINISH;
                case (cmd_reg.operation) inside
                    mpq_pkg::OP_ENQ, mpq_pkg::OP_MOVE, mpq_pkg::OP_SETPRI:
                    begin
                        if (cmd_reg.operation == mpq_pkg::OP_MOVE)
                        begin
                            res_next.pid_out = cmd_reg.pid;
                        end
                        if (cmd_reg.operation == mpq_pkg::OP_SETPRI)
                        begin
                            state_next = S_PREEMPT;
                        end
                        if (cmd_reg.operation != mpq_pkg::OP_ENQ &&
                            !may_enq(cmd_reg.pid, cmd_reg.priority_req))
                        begin
                            if (cmd_reg.operation == mpq_pkg::OP_MOVE)
                            begin
                                res_next.status = mpq_pkg::ST_ERR;
                            end
                        end
                        else if (!hvalid_reg[didx])
                        begin
                            hvalid_next[didx] = 1'b1;
                            head_next[didx] = tpid_reg;
                            tail_next[didx] = tpid_reg;
                        end
                        else
                        begin
                            link_we = 1'b1;
                            link_waddr = tail_reg[didx];
                            link_wdata = tpid_reg;
                            tail_next[didx] = tpid_reg;
                        end
                        if (cmd_reg.operation == mpq_pkg::OP_SETPRI)
                        begin
                            set_next = 1'b0;
                        end
                    end
                    mpq_pkg::OP_REMOVE:
                    begin
                        res_next.pid_out = cmd_reg.pid;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PREEMPT:
            begin
                state_next = S_FINISH;
                if (cmd_reg.blocking && 32'(cmd_reg.current_pid) < PROC_COUNT &&
                    tvalid_reg[PW'(cmd_reg.current_pid)] &&
                    ptab_reg[PW'(cmd_reg.current_pid)] > high_of(hvalid_reg, 1'b0))
                begin
                    res_next.preempt = 1'b1;
                end
            end
            S_FINISH:
            begin
                res_next.highest_level = high_of(hvalid_reg, set_reg);
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rdata_reg <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            hvalid_reg <= '0;
            tvalid_reg <= '0;
            retry_reg <= 1'b0;
            for (int i = 0; i < PROC_COUNT; i++)
            begin
                ptab_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            hvalid_reg <= hvalid_next;
            tvalid_reg <= tvalid_next;
            retry_reg <= retry_next;
            ptab_reg <= ptab_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        set_reg <= set_next;
        src_reg <= src_next;
        tpid_reg <= tpid_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        hasprev_reg <= hasprev_next;
        steps_reg <= steps_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = res_reg;

endmodule

// ----- tb/sv/mpq_checker.sv -----
`timescale 1ns / 100ps

module mpq_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  mpq_pkg::cmd_t cmd,
    input  logic          done,
    input  mpq_pkg::res_t result,
    output int            fails,
    output int            pending
);

    localparam int NP = mpq_pkg::PROC_COUNT_DEF;
    localparam int NL = mpq_pkg::NUM_LEVELS_DEF;
    localparam int LUL = mpq_pkg::LOWEST_USER_LEVEL_DEF;
    localparam int HUL = mpq_pkg::HIGHEST_USER_LEVEL_DEF;

    bit   list_valid [2*NL];
    int   list_head [2*NL];
    int   list_tail [2*NL];
    int   link [NP];
    int   level_of [NP];
    bit   known [NP];
    mpq_pkg::res_t expected_results [$];

    function automatic bit enq_allowed(int id, int lvl);
        if (lvl >= NL)
            return 0;
        if (id == 0)
            return 1;
        return lvl <= LUL && lvl >= HUL;
    endfunction

    function automatic void list_push(int q, int id);
        if (!list_valid[q])
        begin
            list_head[q] = id;
            list_valid[q] = 1;
        end
        else
            link[list_tail[q]] = id;
        list_tail[q] = id;
    endfunction

    function automatic bit list_unlink(int q, int id);
        int cur;
        int prv;
        bit has_prv;
        has_prv = 0;
        prv = 0;
        if (!list_valid[q])
            return 0;
        cur = list_head[q];
        for (int steps = 0; steps < NP; steps++)
        begin
            if (cur == id)
            begin
                if (!has_prv)
                begin
                    if (cur == list_tail[q])
                        list_valid[q] = 0;
                    else
                        list_head[q] = link[cur];
                end
                else if (cur == list_tail[q])
                    list_tail[q] = prv;
                else
                    link[prv] = link[cur];
                return 1;
            end
            if (cur == list_tail[q])
                return 0;
            prv = cur;
            has_prv = 1;
            cur = link[cur];
        end
        return 0;
    endfunction

    function automatic int top_level(int set);
        for (int l = 0; l < NL; l++)
            if (list_valid[set*NL + l])
                return l;
        return NL;
    endfunction

    function automatic logic [1:0] relocate(int set, int id, int src, int dst);
        if (src >= NL || !list_unlink(set*NL + src, id))
            return mpq_pkg::ST_EMPTY;
        if (!enq_allowed(id, dst))
            return mpq_pkg::ST_ERR;
        list_push(set*NL + dst, id);
        return mpq_pkg::ST_OK;
    endfunction

    function automatic mpq_pkg::res_t apply_command(mpq_pkg::cmd_t c);
        mpq_pkg::res_t r;
        int set;
        int id;
        int lvl;
        int prev;
        set = c.queue_sel;
        id = c.pid;
        lvl = c.priority_req;
        r = '0;
        case (c.operation)
            mpq_pkg::OP_ENQ:
            begin
                if (!enq_allowed(id, lvl))
                    r.status = mpq_pkg::ST_ERR;
                else
                    list_push(set*NL + lvl, id);
            end
            mpq_pkg::OP_DEQ:
            begin
                if (lvl >= NL || !list_valid[set*NL + lvl])
                    r.status = mpq_pkg::ST_EMPTY;
                else
                begin
                    r.pid_out = 4'(list_head[set*NL + lvl]);
                    void'(list_unlink(set*NL + lvl, int'(r.pid_out)));
                end
            end
            mpq_pkg::OP_REMOVE:
            begin
                if (lvl >= NL || !list_unlink(set*NL + lvl, id))
                    r.status = mpq_pkg::ST_EMPTY;
                else
                    r.pid_out = 4'(id);
            end
            mpq_pkg::OP_MOVE:
            begin
                r.status = relocate(set, id, c.from_priority, lvl);
                if (r.status != mpq_pkg::ST_EMPTY)
                    r.pid_out = 4'(id);
            end
            mpq_pkg::OP_HIGHEST:
            begin
            end
            mpq_pkg::OP_SETPRI:
            begin
                set = 0;
                if (id == 0 || lvl > LUL || lvl < HUL || lvl >= NL || !known[id])
                    r.status = mpq_pkg::ST_ERR;
                else
                begin
                    prev = level_of[id];
                    level_of[id] = lvl;
                    r.pid_out = 4'(id);
                    if (prev != lvl)
                    begin
                        if (relocate(0, id, prev, lvl) == mpq_pkg::ST_EMPTY)
                            void'(relocate(1, id, prev, lvl));
                        if (c.blocking && known[c.current_pid] &&
                            level_of[c.current_pid] > top_level(0))
                            r.preempt = 1'b1;
                    end
                end
            end
            mpq_pkg::OP_LOAD:
            begin
                set = 0;
                level_of[id] = lvl;
                known[id] = 1;
            end
            default:
                r.status = mpq_pkg::ST_ERR;
        endcase
        r.highest_level = 3'(top_level(set));
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", field, got, want);
        fails++;
    endtask

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        mpq_pkg::res_t want;
        if (!rst_n)
        begin
            fails = 0;
            expected_results.delete();
            for (int q = 0; q < 2*NL; q++)
                list_valid[q] = 0;
            for (int p = 0; p < NP; p++)
            begin
                link[p] = 0;
                level_of[p] = 0;
                known[p] = 0;
            end
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result transfer", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.pid_out !== want.pid_out)
                        report_mismatch("pid_out", result.pid_out, want.pid_out);
                    if (result.highest_level !== want.highest_level)
                        report_mismatch("highest_level", result.highest_level,
                                        want.highest_level);
                    if (result.preempt !== want.preempt)
                        report_mismatch("preempt", result.preempt, want.preempt);
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_command(cmd));
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int NP = mpq_pkg::PROC_COUNT_DEF;
    localparam int CMD_W = $bits(mpq_pkg::cmd_t);

    logic clk;
    logic rst_n;
    logic start;
    mpq_pkg::cmd_t cmd;
    logic busy;
    logic done;
    mpq_pkg::res_t result;
    int   fails;
    int   pending;

    bit   queued [NP];
    int   queued_set [NP];
    int   queued_level [NP];
    bit   steady;

    multilevel_process_ready_queue dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result)
    );

    mpq_checker scoreboard (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .fails(fails),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #2000000;
        $display("tb failed");
        $finish;
    end

    // Membership is tracked so that no process sits in two lists at once.
    task automatic issue(mpq_pkg::cmd_t c);
        mpq_pkg::res_t r;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (!done)
            @(posedge clk);
        r = result;
        case (c.operation)
            mpq_pkg::OP_ENQ:
                if (r.status == mpq_pkg::ST_OK)
                begin
                    queued[c.pid] = 1;
                    queued_set[c.pid] = c.queue_sel;
                    queued_level[c.pid] = c.priority_req;
                end
            mpq_pkg::OP_DEQ:
                if (r.status == mpq_pkg::ST_OK)
                    queued[r.pid_out] = 0;
            mpq_pkg::OP_REMOVE:
                if (r.status == mpq_pkg::ST_OK)
                    queued[c.pid] = 0;
            mpq_pkg::OP_MOVE:
                if (r.status == mpq_pkg::ST_ERR)
                    queued[c.pid] = 0;
                else if (r.status == mpq_pkg::ST_OK)
                    queued_level[c.pid] = c.priority_req;
            mpq_pkg::OP_SETPRI:
                if (r.status == mpq_pkg::ST_OK)
                    queued_level[c.pid] = c.priority_req;
            default:
            begin
            end
        endcase
        while (!steady && $urandom_range(99) < 29)
            @(posedge clk);
    endtask

    function automatic mpq_pkg::cmd_t make_cmd(logic [2:0] op, int id, int lvl, int src,
                                               int set, int running, int blk);
        mpq_pkg::cmd_t c;
        c.operation = op;
        c.queue_sel = 1'(set);
        c.pid = 4'(id);
        c.priority_req = 3'(lvl);
        c.from_priority = 3'(src);
        c.current_pid = 4'(running);
        c.blocking = 1'(blk);
        return c;
    endfunction

    function automatic mpq_pkg::cmd_t random_cmd();
        mpq_pkg::cmd_t c;
        int pick;
        int id;
        c = CMD_W'($urandom);
        id = int'($urandom_range(NP - 1));
        pick = int'($urandom_range(99));
        if (pick < 30)
        begin
            if (queued[id])
                c.operation = mpq_pkg::OP_HIGHEST;
            else
            begin
                c.operation = mpq_pkg::OP_ENQ;
                c.pid = 4'(id);
                c.priority_req = 3'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                             : $urandom_range(4));
            end
        end
        else if (pick < 45)
        begin
            c.operation = mpq_pkg::OP_DEQ;
            c.priority_req = 3'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                         : $urandom_range(4));
        end
        else if (pick < 70)
        begin
            c.operation = (pick < 57) ? mpq_pkg::OP_REMOVE : mpq_pkg::OP_MOVE;
            c.pid = 4'(id);
            if (queued[id] && $urandom_range(3) != 0)
            begin
                c.queue_sel = 1'(queued_set[id]);
                c.from_priority = 3'(queued_level[id]);
                if (c.operation == mpq_pkg::OP_REMOVE)
                    c.priority_req = 3'(queued_level[id]);
                else
                    c.priority_req = 3'($urandom_range(4));
            end
        end
        else if (pick < 76)
            c.operation = mpq_pkg::OP_HIGHEST;
        else if (pick < 88)
        begin
            c.operation = mpq_pkg::OP_SETPRI;
            c.priority_req = 3'(($urandom_range(7) == 0) ? $urandom_range(7)
                                                         : $urandom_range(3));
        end
        else if (pick < 97)
            c.operation = mpq_pkg::OP_LOAD;
        else
            c.operation = mpq_pkg::OP_ILLEGAL;
        return c;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        steady = 0;
        for (int p = 0; p < NP; p++)
            queued[p] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(make_cmd(mpq_pkg::OP_HIGHEST, 0, 0, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_DEQ, 0, 0, 0, 1, 0, 0));
        issue(make_cmd(mpq_pkg::OP_DEQ, 0, 7, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_LOAD, 15, 7, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_LOAD, 3, 2, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_LOAD, 9, 0, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ENQ, 0, 4, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ENQ, 5, 4, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ENQ, 6, 5, 0, 1, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ENQ, 3, 2, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ENQ, 15, 3, 0, 1, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ENQ, 9, 0, 0, 1, 0, 0));
        issue(make_cmd(mpq_pkg::OP_REMOVE, 7, 2, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_MOVE, 3, 6, 2, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ENQ, 3, 2, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_SETPRI, 0, 1, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_SETPRI, 4, 1, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_SETPRI, 3, 5, 0, 0, 0, 0));
        issue(make_cmd(mpq_pkg::OP_SETPRI, 3, 2, 0, 0, 0, 1));
        issue(make_cmd(mpq_pkg::OP_SETPRI, 3, 1, 0, 0, 15, 1));
        issue(make_cmd(mpq_pkg::OP_SETPRI, 15, 0, 0, 0, 15, 1));
        issue(make_cmd(mpq_pkg::OP_MOVE, 9, 3, 0, 1, 0, 0));
        issue(make_cmd(mpq_pkg::OP_ILLEGAL, 15, 7, 7, 1, 15, 1));
        issue(make_cmd(mpq_pkg::OP_HIGHEST, 0, 0, 0, 1, 0, 0));

        for (int n = 0; n < 600; n++)
        begin
            steady = (n >= 250 && n < 350);
            issue(random_cmd());
        end

        for (int w = 0; w < 100 && pending != 0; w++)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
